// File: hdl/word_frequency_table_assert.svh
// Assertion macros used by the checker file of the word frequency table.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef WORD_FREQUENCY_TABLE_ASSERT_SVH
`define WORD_FREQUENCY_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/wft_pkg.sv
// Package of the word frequency table: request kinds, queue entry and result types,
// sequencer states and default sizes. Depends on nothing.
package wft_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned STOP_DEPTH_DEF  = 64;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned RIDX_W  = 10;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned UNIQ_W  = 11;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_COUNT,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [RIDX_W-1:0] ridx;
  } item_t;

  typedef struct packed {
    logic               is_stop;
    logic               is_new;
    logic [RIDX_W-1:0]  entry_index;
    logic [COUNT_W-1:0] entry_count;
    logic [KEY_W-1:0]   entry_word;
    logic [UNIQ_W-1:0]  unique_words;
    logic [COUNT_W-1:0] stop_total;
    logic               full_flag;
    logic               index_valid;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SSCAN,
    S_TSCAN,
    S_RWAIT
  } state_t;

endpackage

// File: hdl/wft_front.sv
// Front end of the word frequency table: takes requests, classifies the kind and
// holds them in a two-entry queue for the back end. Depends on wft_pkg.
module wft_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [1:0]      in_kind,
  input  logic [63:0]     in_key,
  input  logic [9:0]      in_ridx,
  output logic            q_valid,
  output wft_pkg::item_t  q_item,
  input  logic            q_pop
);

  wft_pkg::item_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  wft_pkg::item_t cls;
  logic           push;

  always_comb begin
    cls.key  = in_key;
    cls.ridx = in_ridx;
    unique case (in_kind)
      wft_pkg::KIND_LOAD:  cls.op = wft_pkg::OP_LOAD;
      wft_pkg::KIND_COUNT: cls.op = wft_pkg::OP_COUNT;
      wft_pkg::KIND_READ:  cls.op = wft_pkg::OP_READ;
      default:             cls.op = wft_pkg::OP_NONE;
    endcase
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: hdl/wft_back.sv
// Back end of the word frequency table: sequencer that scans the stop list and the
// word table memories one entry a cycle and fills the result register. Depends on wft_pkg.
module wft_back #(
  parameter int unsigned TABLE_DEPTH = wft_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned STOP_DEPTH  = wft_pkg::STOP_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  wft_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output wft_pkg::res_t   out_res
);

  localparam int unsigned SAW = (STOP_DEPTH > 1) ? $clog2(STOP_DEPTH) : 1;
  localparam int unsigned SCW = SAW + 1;
  localparam int unsigned TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TCW = TAW + 1;

  logic [63:0] stop_mem [STOP_DEPTH];
  logic [63:0] word_mem [TABLE_DEPTH];
  logic [31:0] cnt_mem  [TABLE_DEPTH];

  wft_pkg::state_t state_r, state_nxt;
  wft_pkg::item_t  item_r;
  logic [SCW-1:0]  sscan_r, sscan_nxt;
  logic            spend_r, spend_nxt;
  logic [TCW-1:0]  tscan_r, tscan_nxt;
  logic            tpend_r, tpend_nxt;
  logic [TAW-1:0]  tpidx_r, tpidx_nxt;
  logic [SCW-1:0]  stop_used_r, stop_used_nxt;
  logic [TCW-1:0]  tab_used_r, tab_used_nxt;
  logic [31:0]     stop_hits_r, stop_hits_nxt;
  logic            out_valid_r;
  wft_pkg::res_t   out_res_r, res;
  logic            res_load;

  logic [63:0]     sdata_r, wdata_r;
  logic [31:0]     cdata_r;
  logic [SAW-1:0]  s_raddr;
  logic [TAW-1:0]  t_raddr;
  logic            s_we, w_we, c_we;
  logic [TAW-1:0]  c_waddr;
  logic [31:0]     c_wdata, cnt_inc;
  logic            shit, thit, rd_in_range;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign q_pop     = (state_r == wft_pkg::S_IDLE) && q_valid && !out_valid_r;

  assign shit        = spend_r && (sdata_r == item_r.key);
  assign thit        = tpend_r && (wdata_r == item_r.key);
  assign cnt_inc     = (cdata_r == '1) ? cdata_r : cdata_r + 32'd1;
  assign rd_in_range = 32'(item_r.ridx) < 32'(tab_used_r);
  assign s_raddr     = sscan_r[SAW-1:0];
  assign t_raddr     = (state_r == wft_pkg::S_DISPATCH) ? TAW'(item_r.ridx)
                                                        : tscan_r[TAW-1:0];

  always_comb begin
    state_nxt     = state_r;
    sscan_nxt     = sscan_r;
    spend_nxt     = 1'b0;
    tscan_nxt     = tscan_r;
    tpend_nxt     = 1'b0;
    tpidx_nxt     = tpidx_r;
    stop_used_nxt = stop_used_r;
    tab_used_nxt  = tab_used_r;
    stop_hits_nxt = stop_hits_r;
    s_we          = 1'b0;
    w_we          = 1'b0;
    c_we          = 1'b0;
    c_waddr       = tpidx_r;
    c_wdata       = cnt_inc;
    res_load      = 1'b0;
    res           = '0;

    unique case (state_r)
      wft_pkg::S_IDLE: begin
        if (q_pop) begin
          state_nxt = wft_pkg::S_DISPATCH;
        end
      end
      wft_pkg::S_DISPATCH: begin
        unique case (item_r.op)
          wft_pkg::OP_LOAD: begin
            if (32'(stop_used_r) < STOP_DEPTH) begin
              s_we          = 1'b1;
              stop_used_nxt = stop_used_r + SCW'(1);
            end else begin
              res.full_flag = 1'b1;
            end
            res_load  = 1'b1;
            state_nxt = wft_pkg::S_IDLE;
          end
          wft_pkg::OP_COUNT: begin
            sscan_nxt = '0;
            state_nxt = wft_pkg::S_SSCAN;
          end
          wft_pkg::OP_READ: begin
            if (rd_in_range) begin
              state_nxt = wft_pkg::S_RWAIT;
            end else begin
              res_load  = 1'b1;
              state_nxt = wft_pkg::S_IDLE;
            end
          end
          default: begin
            res_load  = 1'b1;
            state_nxt = wft_pkg::S_IDLE;
          end
        endcase
      end
      wft_pkg::S_SSCAN: begin
        if (shit) begin
          if (stop_hits_r != '1) begin
            stop_hits_nxt = stop_hits_r + 32'd1;
          end
          res.is_stop = 1'b1;
          res_load    = 1'b1;
          state_nxt   = wft_pkg::S_IDLE;
        end else if (sscan_r < stop_used_r) begin
          spend_nxt = 1'b1;
          sscan_nxt = sscan_r + SCW'(1);
        end else begin
          tscan_nxt = '0;
          state_nxt = wft_pkg::S_TSCAN;
        end
      end
      wft_pkg::S_TSCAN: begin
        if (thit) begin
          c_we             = 1'b1;
          res.entry_index  = 10'(tpidx_r);
          res.entry_count  = cnt_inc;
          res.entry_word   = wdata_r;
          res_load         = 1'b1;
          state_nxt        = wft_pkg::S_IDLE;
        end else if (tscan_r < tab_used_r) begin
          tpend_nxt = 1'b1;
          tpidx_nxt = tscan_r[TAW-1:0];
          tscan_nxt = tscan_r + TCW'(1);
        end else if (32'(tab_used_r) < TABLE_DEPTH) begin
          // New word: append it behind the last stored entry.
          w_we            = 1'b1;
          c_we            = 1'b1;
          c_waddr         = tab_used_r[TAW-1:0];
          c_wdata         = 32'd1;
          tab_used_nxt    = tab_used_r + TCW'(1);
          res.is_new      = 1'b1;
          res.entry_index = 10'(tab_used_r);
          res.entry_count = 32'd1;
          res.entry_word  = item_r.key;
          res_load        = 1'b1;
          state_nxt       = wft_pkg::S_IDLE;
        end else begin
          res.full_flag = 1'b1;
          res_load      = 1'b1;
          state_nxt     = wft_pkg::S_IDLE;
        end
      end
      wft_pkg::S_RWAIT: begin
        res.index_valid = 1'b1;
        res.entry_index = item_r.ridx;
        res.entry_count = cdata_r;
        res.entry_word  = wdata_r;
        res_load        = 1'b1;
        state_nxt       = wft_pkg::S_IDLE;
      end
      default: begin
        state_nxt = wft_pkg::S_IDLE;
      end
    endcase

    res.unique_words = 11'(tab_used_nxt);
    res.stop_total   = stop_hits_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wft_pkg::S_IDLE;
      sscan_r     <= '0;
      spend_r     <= 1'b0;
      tscan_r     <= '0;
      tpend_r     <= 1'b0;
      stop_used_r <= '0;
      tab_used_r  <= '0;
      stop_hits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sscan_r     <= sscan_nxt;
      spend_r     <= spend_nxt;
      tscan_r     <= tscan_nxt;
      tpend_r     <= tpend_nxt;
      stop_used_r <= stop_used_nxt;
      tab_used_r  <= tab_used_nxt;
      stop_hits_r <= stop_hits_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tpidx_r <= tpidx_nxt;
    if (q_pop) begin
      item_r <= q_item;
    end
    if (res_load) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stop_mem[stop_used_r[SAW-1:0]] <= item_r.key;
    end
    sdata_r <= stop_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      word_mem[tab_used_r[TAW-1:0]] <= item_r.key;
    end
    wdata_r <= word_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cnt_mem[c_waddr] <= c_wdata;
    end
    cdata_r <= cnt_mem[t_raddr];
  end

endmodule

// File: hdl/word_frequency_table.sv
// Word frequency table with stop list. Load, unused kind and out-of-range read are answered
// straight from dispatch; an in-range read waits for its table read. A count scans the stop
// list and ends on a stop hit, else scans the used table entries for a match, or appends a
// new word, or drops it when the table is full; each scan reads one entry a cycle. A two-entry
// queue keeps accepting requests, until it is full, while the back end works on one item.
// Reset (rst_n low, synchronous) clears counts and queue; memories get no clearing pass.
module word_frequency_table #(
  parameter int unsigned TABLE_DEPTH = wft_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned STOP_DEPTH  = wft_pkg::STOP_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // [63:0] word_key, [73:64] read_index, rest zero
  input  logic [1:0]   in_tuser,   // [1:0] kind
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // is_stop, is_new, entry_index, entry_count, entry_word,
                                   // unique_words, stop_total, full_flag, index_valid, zeros
);

  // The front end decodes each request into an operation and queues it, so the
  // upstream tokenizer is not held while the back end walks its memories, unless the queue is full.
  logic           q_valid;
  logic           q_pop;
  wft_pkg::item_t q_item;
  wft_pkg::res_t  res;

  wft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_key    (in_tdata[63:0]),
    .in_ridx   (in_tdata[73:64]),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // The back end holds the stop list and the table and owns the result register;
  // it takes the next request only once the previous result has been delivered.
  wft_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .STOP_DEPTH  (STOP_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Result fields packed from the lowest bit up.
  assign out_tdata = {7'd0, res.index_valid, res.full_flag, res.stop_total,
                      res.unique_words, res.entry_word, res.entry_count,
                      res.entry_index, res.is_new, res.is_stop};

endmodule

// File: hdl/wft_checker.sv
// Port-level checker for the word frequency table, bound to the top level.
// Depends on word_frequency_table_assert.svh.
`include "word_frequency_table_assert.svh"

module wft_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);

  `WFT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")
  `WFT_ASSERT_NOW(a_stop_new, out_tvalid, !(out_tdata[0] && out_tdata[1]), "stop hit also flagged as new")
  `WFT_ASSERT_NOW(a_full_excl, out_tvalid && out_tdata[151], !out_tdata[1] && !out_tdata[152] && !out_tdata[0], "full result carries entry flags")
  `WFT_ASSERT_NOW(a_new_one, out_tvalid && out_tdata[1], out_tdata[43:12] == 32'd1, "new entry count is not one")

endmodule

bind word_frequency_table wft_checker u_wft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: verif/tb.sv
// Self-checking bench for word_frequency_table: drives count, load, read and unused-kind
// requests and checks every result against a behavioral model of the stop list and word
// table, or against a typed expectation. Depends on wft_pkg and the word_frequency_table RTL.
module tb;

  localparam logic [1:0] KIND_IDLE = 2'd3;   // unused kind: no state change
  localparam int TABLE_N    = 1024;
  localparam int STOP_N     = 64;
  localparam int POOL_N     = 48;
  localparam int RAND_ITEMS = 480;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 6000;
  localparam logic [31:0] SAT = 32'hFFFF_FFFF;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;

  word_frequency_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Model state of the stop list and the word table.
  logic [63:0] stop_words [STOP_N];
  int          stops_loaded;
  logic [63:0] words      [TABLE_N];
  logic [31:0] counts     [TABLE_N];
  int          words_used;
  logic [31:0] stop_hit_total;

  wft_pkg::res_t pending_results[$];
  int          errors;
  int          results_seen;
  int          requests_sent;
  bit          quiet;          // when set, neither side inserts random gaps
  logic [63:0] word_pool [POOL_N];

  // Applies one request to the model and returns the result it should produce.
  function automatic wft_pkg::res_t predict_tally(logic [1:0] kind, logic [63:0] key,
                                                  logic [9:0] ridx);
    wft_pkg::res_t r;
    int   hit;
    r = '0;
    hit = -1;
    if (kind == wft_pkg::KIND_LOAD) begin
      if (stops_loaded < STOP_N) begin
        stop_words[stops_loaded] = key;
        stops_loaded++;
      end else begin
        r.full_flag = 1'b1;
      end
    end else if (kind == wft_pkg::KIND_COUNT) begin
      for (int i = 0; i < stops_loaded; i++)
        if (stop_words[i] == key) hit = i;
      if (hit >= 0) begin
        r.is_stop = 1'b1;
        if (stop_hit_total != SAT) stop_hit_total++;
      end else begin
        for (int i = words_used - 1; i >= 0; i--)
          if (words[i] == key) hit = i;
        if (hit >= 0) begin
          if (counts[hit] != SAT) counts[hit]++;
          r.entry_index = hit[9:0];
          r.entry_count = counts[hit];
          r.entry_word  = words[hit];
        end else if (words_used < TABLE_N) begin
          words[words_used]  = key;
          counts[words_used] = 32'd1;
          r.is_new      = 1'b1;
          r.entry_index = words_used[9:0];
          r.entry_count = 32'd1;
          r.entry_word  = key;
          words_used++;
        end else begin
          r.full_flag = 1'b1;
        end
      end
    end else if (kind == wft_pkg::KIND_READ) begin
      if (int'(ridx) < words_used) begin
        r.index_valid = 1'b1;
        r.entry_index = ridx;
        r.entry_count = counts[ridx];
        r.entry_word  = words[ridx];
      end
    end
    r.unique_words = words_used[10:0];
    r.stop_total   = stop_hit_total;
    return r;
  endfunction

  // Offers one request after a random gap (none while quiet) and waits for the handshake. The
  // expectation is recorded at the accepting edge; a typed one overrides the model.
  task automatic send_request(logic [1:0] kind, logic [63:0] key, logic [9:0] ridx,
                              bit typed, wft_pkg::res_t typed_res);
    int   gap;
    wft_pkg::res_t r;
    gap = quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, ridx, key};
    do @(posedge clk); while (!in_tready);
    r = predict_tally(kind, key, ridx);
    pending_results.push_back(typed ? typed_res : r);
    requests_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed table: kind, key, index, and an expected result where it is obvious.
  typedef struct {
    logic [1:0]    kind;
    logic [63:0]   key;
    logic [9:0]    ridx;
    bit            typed;
    wft_pkg::res_t res;
  } row_t;

  row_t rows[$];

  function automatic row_t mk_row(logic [1:0] kind, logic [63:0] key, logic [9:0] ridx,
                                  bit typed, wft_pkg::res_t res);
    row_t w;
    w.kind = kind; w.key = key; w.ridx = ridx; w.typed = typed; w.res = res;
    return w;
  endfunction

  initial begin
    wft_pkg::res_t e;
    logic [63:0] k;
    int pick;
    logic [9:0] ri;

    errors = 0; results_seen = 0; requests_sent = 0;
    stops_loaded = 0; words_used = 0; stop_hit_total = '0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    for (int i = 0; i < POOL_N; i++) word_pool[i] = {$urandom, $urandom};
    word_pool[0] = 64'h7468_6500_0000_0000;   // "the"
    word_pool[1] = 64'h616E_6400_0000_0000;   // "and"

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A read on the empty table and the unused kind report nothing.
    e = '0;
    rows.push_back(mk_row(wft_pkg::KIND_READ, '0, 10'd0, 1, e));
    rows.push_back(mk_row(KIND_IDLE, '1, 10'd1023, 1, e));
    // The all-zero key is an ordinary word while no stop word is loaded.
    e = '0; e.is_new = 1; e.entry_count = 1; e.unique_words = 1;
    rows.push_back(mk_row(wft_pkg::KIND_COUNT, '0, 10'd0, 1, e));
    e = '0; e.unique_words = 1;
    rows.push_back(mk_row(wft_pkg::KIND_READ, '0, 10'd1023, 1, e));
    rows.push_back(mk_row(wft_pkg::KIND_LOAD, '0, 10'd0, 1, e));
    // Once loaded, the same key is a stop hit.
    e = '0; e.is_stop = 1; e.unique_words = 1; e.stop_total = 1;
    rows.push_back(mk_row(wft_pkg::KIND_COUNT, '0, 10'd0, 1, e));
    e = '0;
    rows.push_back(mk_row(wft_pkg::KIND_LOAD, '0, 10'd0, 0, e));          // duplicate stop word
    rows.push_back(mk_row(wft_pkg::KIND_COUNT, '1, 10'd0, 0, e));
    rows.push_back(mk_row(wft_pkg::KIND_COUNT, '1, 10'd1023, 0, e));       // repeat match
    rows.push_back(mk_row(wft_pkg::KIND_COUNT, word_pool[0], 10'd0, 0, e));
    rows.push_back(mk_row(wft_pkg::KIND_LOAD, word_pool[1], 10'd0, 0, e));
    rows.push_back(mk_row(wft_pkg::KIND_COUNT, word_pool[1], 10'd0, 0, e));
    rows.push_back(mk_row(wft_pkg::KIND_READ, '0, 10'd0, 0, e));
    rows.push_back(mk_row(wft_pkg::KIND_READ, '0, 10'd1, 0, e));
    rows.push_back(mk_row(wft_pkg::KIND_READ, '0, 10'd2, 0, e));
    rows.push_back(mk_row(wft_pkg::KIND_READ, '0, 10'd3, 0, e));
    rows.push_back(mk_row(KIND_IDLE, 64'h5555_AAAA_0F0F_F0F0, 10'd512, 0, e));

    foreach (rows[i]) send_request(rows[i].kind, rows[i].key, rows[i].ridx,
                                   rows[i].typed, rows[i].res);

    // Random traffic over a small vocabulary so words repeat and stop hits occur.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      k  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                       : word_pool[$urandom_range(0, POOL_N - 1)];
      ri = ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                       : 10'($urandom_range(0, words_used + 2));
      if (pick < 18)
        send_request(wft_pkg::KIND_LOAD, k, 10'($urandom), 0, e);
      else if (pick < 75)
        send_request(wft_pkg::KIND_COUNT, k, 10'($urandom), 0, e);
      else if (pick < 94)
        send_request(wft_pkg::KIND_READ, {$urandom, $urandom}, ri, 0, e);
      else
        send_request(KIND_IDLE, {$urandom, $urandom}, 10'($urandom), 0, e);
    end

    // A few fresh words, a read past the used entries and a load on the full stop list.
    quiet = 1'b1;
    send_request(wft_pkg::KIND_COUNT, 64'hDEAD_BEEF_0000_0001, 10'd0, 0, e);
    send_request(wft_pkg::KIND_COUNT, 64'hDEAD_BEEF_0000_0002, 10'd0, 0, e);
    send_request(wft_pkg::KIND_READ, '0, 10'd1023, 0, e);
    send_request(wft_pkg::KIND_COUNT, {32'hF1E1_D000, 32'd5}, 10'd0, 0, e);
    send_request(wft_pkg::KIND_LOAD, '1, 10'd0, 0, e);
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("tb: %0d requests, %0d results; %0d words stored, %0d stop words, %0d stop hits",
             requests_sent, results_seen, words_used, stops_loaded, stop_hit_total);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Result side: random stalls per result, and one long hold-off so that the
  // two-entry request queue fills and the block stalls its input.
  initial begin
    int   stall;
    bit   held;
    wft_pkg::res_t want;
    wft_pkg::res_t got;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (!held && results_seen == 150) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      got = '0;
      got.is_stop      = out_tdata[0];
      got.is_new       = out_tdata[1];
      got.entry_index  = out_tdata[11:2];
      got.entry_count  = out_tdata[43:12];
      got.entry_word   = out_tdata[107:44];
      got.unique_words = out_tdata[118:108];
      got.stop_total   = out_tdata[150:119];
      got.full_flag    = out_tdata[151];
      got.index_valid  = out_tdata[152];
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          errors++;
          $display("%0t: mismatch, expected stop=%b new=%b idx=%0d cnt=%0d word=%h uniq=%0d",
                   $time, want.is_stop, want.is_new, want.entry_index, want.entry_count,
                   want.entry_word, want.unique_words);
          $display("%0t:   ... stops=%0d full=%b valid=%b; actual stop=%b new=%b idx=%0d",
                   $time, want.stop_total, want.full_flag, want.index_valid,
                   got.is_stop, got.is_new, got.entry_index);
          $display("%0t:   ... cnt=%0d word=%h uniq=%0d stops=%0d full=%b valid=%b",
                   $time, got.entry_count, got.entry_word, got.unique_words,
                   got.stop_total, got.full_flag, got.index_valid);
        end
      end
    end
  end

  // Watchdog: too many cycles without any handshake on either side ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("tb: timeout with %0d results outstanding", pending_results.size());
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule
